FILE: rtl/core/ptns_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptns_pkg
// Shared constants, codes and types of the point table nearest search block.
// ----------------------------------------------------------------------------

package ptns_pkg;

   localparam int CAPACITY_DEF   = 64;
   localparam int COORD_BITS_DEF = 16;

   localparam int FIELD_BITS     = 16;
   localparam int ID_BITS        = 7;
   localparam int ACTION_BITS    = 2;
   localparam int STATUS_BITS    = 2;
   localparam int DIST_BITS      = 33;
   localparam int REQ_TDATA_BITS = 40;
   localparam int RSP_TDATA_BITS = 72;

   localparam logic [ACTION_BITS-1:0] ACT_ADD    = 2'd0;
   localparam logic [ACTION_BITS-1:0] ACT_DELETE = 2'd1;
   localparam logic [ACTION_BITS-1:0] ACT_QUERY  = 2'd2;

   localparam logic [STATUS_BITS-1:0] STAT_OK   = 2'd0;
   localparam logic [STATUS_BITS-1:0] STAT_MISS = 2'd1;
   localparam logic [STATUS_BITS-1:0] STAT_FULL = 2'd2;

   typedef enum logic [1:0] {
      CELL_HOLD   = 2'd0,
      CELL_WRITE  = 2'd1,
      CELL_ROTATE = 2'd2,
      CELL_SHIFT  = 2'd3
   } cell_op_type;

   typedef struct packed {
      cell_op_type        op;
      logic [ID_BITS-1:0] tid;
   } cell_ctl_type;

   typedef struct packed {
      logic tok;
      logic found;
   } tok_type;

endpackage

FILE: rtl/core/ptns_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptns_cell
// One table entry: holds a point and its id, takes its neighbor's entry on a
// rotate or a shift, and passes the delete search token down the chain.
// ----------------------------------------------------------------------------

module ptns_cell #(
   parameter int COORD_BITS = ptns_pkg::COORD_BITS_DEF,
   parameter int CNT_W      = 7,
   parameter int IDX        = 0
) (
   input  logic                         clock,
   input  logic                         reset,
   input  ptns_pkg::cell_ctl_type       ctl,
   input  logic [CNT_W-1:0]             count,
   input  logic signed [COORD_BITS-1:0] wr_x,
   input  logic signed [COORD_BITS-1:0] wr_y,
   input  logic [ptns_pkg::ID_BITS-1:0] wr_id,
   input  logic signed [COORD_BITS-1:0] nxt_x,
   input  logic signed [COORD_BITS-1:0] nxt_y,
   input  logic [ptns_pkg::ID_BITS-1:0] nxt_id,
   input  ptns_pkg::tok_type            tok_in,
   output logic signed [COORD_BITS-1:0] x,
   output logic signed [COORD_BITS-1:0] y,
   output logic [ptns_pkg::ID_BITS-1:0] id,
   output ptns_pkg::tok_type            tok_out
);

   logic signed [COORD_BITS-1:0] x_ff, x_in;
   logic signed [COORD_BITS-1:0] y_ff, y_in;
   logic [ptns_pkg::ID_BITS-1:0] id_ff, id_in;
   ptns_pkg::tok_type            tok_ff, tok_in_nxt;
   logic                         flag_ff, flag_in;
   logic                         live;
   logic                         found_here;

   assign live       = CNT_W'(IDX) < count;
   assign found_here = tok_in.found | (live && (id_ff == ctl.tid));

   always_comb begin
      x_in  = x_ff;
      y_in  = y_ff;
      id_in = id_ff;
      unique case (ctl.op)
         ptns_pkg::CELL_HOLD: begin
         end
         ptns_pkg::CELL_WRITE: begin
            if (count == CNT_W'(IDX)) begin
               x_in  = wr_x;
               y_in  = wr_y;
               id_in = wr_id;
            end
         end
         ptns_pkg::CELL_ROTATE: begin
            x_in  = nxt_x;
            y_in  = nxt_y;
            id_in = nxt_id;
         end
         ptns_pkg::CELL_SHIFT: begin
            if (flag_ff) begin
               x_in  = nxt_x;
               y_in  = nxt_y;
               id_in = nxt_id;
            end
         end
      endcase
   end

   always_comb begin
      tok_in_nxt.tok   = tok_in.tok;
      tok_in_nxt.found = tok_in.tok ? found_here : tok_ff.found;
      flag_in          = tok_in.tok ? found_here : flag_ff;
   end

   always_ff @(posedge clock) begin
      x_ff  <= x_in;
      y_ff  <= y_in;
      id_ff <= id_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff  <= '0;
         flag_ff <= 1'b0;
      end else begin
         tok_ff  <= tok_in_nxt;
         flag_ff <= flag_in;
      end
   end

   assign x       = x_ff;
   assign y       = y_ff;
   assign id      = id_ff;
   assign tok_out = tok_ff;

endmodule

FILE: rtl/core/ptns_dist.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptns_dist
// Three-stage squared distance pipeline that keeps the nearest entry seen
// since the last start, the earliest one on a tie.
// ----------------------------------------------------------------------------

module ptns_dist #(
   parameter int COORD_BITS = ptns_pkg::COORD_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic                           in_valid,
   input  logic signed [COORD_BITS-1:0]   head_x,
   input  logic signed [COORD_BITS-1:0]   head_y,
   input  logic [ptns_pkg::ID_BITS-1:0]   head_id,
   input  logic signed [COORD_BITS-1:0]   qry_x,
   input  logic signed [COORD_BITS-1:0]   qry_y,
   output logic signed [COORD_BITS-1:0]   best_x,
   output logic signed [COORD_BITS-1:0]   best_y,
   output logic [ptns_pkg::ID_BITS-1:0]   best_id,
   output logic [2*COORD_BITS:0]          best_d
);

   localparam int SQ_W = 2 * COORD_BITS;
   localparam int D_W  = SQ_W + 1;

   logic signed [COORD_BITS:0]   diff_x, diff_y;
   logic [COORD_BITS-1:0]        abs_x, abs_y;
   logic [D_W-1:0]               sum_d;

   logic                         v1_ff, v2_ff;
   logic [COORD_BITS-1:0]        dx1_ff, dy1_ff;
   logic signed [COORD_BITS-1:0] x1_ff, y1_ff, x2_ff, y2_ff;
   logic [ptns_pkg::ID_BITS-1:0] id1_ff, id2_ff;
   logic [SQ_W-1:0]              sx2_ff, sy2_ff;

   logic                         best_v_ff, best_v_in;
   logic signed [COORD_BITS-1:0] best_x_ff, best_x_in, best_y_ff, best_y_in;
   logic [ptns_pkg::ID_BITS-1:0] best_id_ff, best_id_in;
   logic [D_W-1:0]               best_d_ff, best_d_in;

   assign diff_x = {head_x[COORD_BITS-1], head_x} - {qry_x[COORD_BITS-1], qry_x};
   assign diff_y = {head_y[COORD_BITS-1], head_y} - {qry_y[COORD_BITS-1], qry_y};
   assign abs_x  = diff_x[COORD_BITS] ? COORD_BITS'(-diff_x) : diff_x[COORD_BITS-1:0];
   assign abs_y  = diff_y[COORD_BITS] ? COORD_BITS'(-diff_y) : diff_y[COORD_BITS-1:0];
   assign sum_d  = D_W'(sx2_ff) + D_W'(sy2_ff);

   always_comb begin
      best_v_in  = best_v_ff;
      best_x_in  = best_x_ff;
      best_y_in  = best_y_ff;
      best_id_in = best_id_ff;
      best_d_in  = best_d_ff;
      if (start) begin
         best_v_in = 1'b0;
      end else if (v2_ff && (!best_v_ff || (sum_d < best_d_ff))) begin
         best_v_in  = 1'b1;
         best_x_in  = x2_ff;
         best_y_in  = y2_ff;
         best_id_in = id2_ff;
         best_d_in  = sum_d;
      end
   end

   always_ff @(posedge clock) begin
      dx1_ff     <= abs_x;
      dy1_ff     <= abs_y;
      x1_ff      <= head_x;
      y1_ff      <= head_y;
      id1_ff     <= head_id;
      sx2_ff     <= dx1_ff * dx1_ff;
      sy2_ff     <= dy1_ff * dy1_ff;
      x2_ff      <= x1_ff;
      y2_ff      <= y1_ff;
      id2_ff     <= id1_ff;
      best_x_ff  <= best_x_in;
      best_y_ff  <= best_y_in;
      best_id_ff <= best_id_in;
      best_d_ff  <= best_d_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff     <= 1'b0;
         v2_ff     <= 1'b0;
         best_v_ff <= 1'b0;
      end else begin
         v1_ff     <= in_valid;
         v2_ff     <= v1_ff;
         best_v_ff <= best_v_in;
      end
   end

   assign best_x  = best_x_ff;
   assign best_y  = best_y_ff;
   assign best_id = best_id_ff;
   assign best_d  = best_d_ff;

endmodule

FILE: rtl/core/point_table_nearest_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_table_nearest_search
// Ordered table of 2-D points with add, delete by id and nearest-point query.
// ----------------------------------------------------------------------------
// The table lives in a ring of CAPACITY cells, one entry each. An add, an unused
// action code or a query on an empty table is answered without walking the ring.
// A delete walks the whole ring, hit or miss: a search token passes one cell per
// cycle, marks every cell from the first match on, and then those cells take
// their neighbor's entry in one shift. A query rotates the ring once, handing
// one entry per cycle to a single squared-distance pipeline of three stages.
// One request is worked on at a time, and the next one can be accepted in the
// cycle after a result is loaded. A finished result waits in the output register
// while the next request is accepted; a result still waiting there holds the
// following one back.
// ----------------------------------------------------------------------------

module point_table_nearest_search #(
   parameter int CAPACITY   = ptns_pkg::CAPACITY_DEF,
   parameter int COORD_BITS = ptns_pkg::COORD_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // pos_x[15:0], pos_y[31:16], target_id[38:32], zero fill[39].
   input  logic [ptns_pkg::REQ_TDATA_BITS-1:0]  req_tdata,
   // action[1:0].
   input  logic [ptns_pkg::ACTION_BITS-1:0]     req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // found_id[6:0], found_x[22:7], found_y[38:23], dist_sq[71:39].
   output logic [ptns_pkg::RSP_TDATA_BITS-1:0]  rsp_tdata,
   // status[1:0].
   output logic [ptns_pkg::STATUS_BITS-1:0]     rsp_tuser
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int D_W   = 2 * COORD_BITS + 1;
   localparam int IDB   = ptns_pkg::ID_BITS;
   localparam int FB    = ptns_pkg::FIELD_BITS;

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_QUERY  = 5'b00010,
      S_DRAIN  = 5'b00100,
      S_DELETE = 5'b01000,
      S_DONE   = 5'b10000
   } state_type;

   state_type                          state_ff, state_in;
   logic [CNT_W-1:0]                   count_ff, count_in;
   logic [IDX_W-1:0]                   step_ff, step_in;
   logic                               drain_ff, drain_in;
   logic                               del_go_ff, del_go_in;
   logic [IDB-1:0]                     tid_ff, tid_in;
   logic signed [COORD_BITS-1:0]       qx_ff, qx_in, qy_ff, qy_in;
   logic [ptns_pkg::STATUS_BITS-1:0]   res_status_ff, res_status_in;
   logic [IDB-1:0]                     res_id_ff, res_id_in;
   logic                               res_query_ff, res_query_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [ptns_pkg::STATUS_BITS-1:0]   rsp_tuser_ff, rsp_tuser_in;
   logic [ptns_pkg::RSP_TDATA_BITS-1:0] rsp_tdata_ff, rsp_tdata_in;

   logic                               accept;
   logic [ptns_pkg::ACTION_BITS-1:0]   action;
   logic signed [COORD_BITS-1:0]       pos_x, pos_y;
   logic [IDB-1:0]                     target_id;
   logic [IDB-1:0]                     new_id;
   logic [CNT_W:0]                     count_inc;
   logic                               dist_start;
   logic                               head_valid;
   ptns_pkg::cell_ctl_type             ctl;

   logic signed [COORD_BITS-1:0]       cell_x [CAPACITY];
   logic signed [COORD_BITS-1:0]       cell_y [CAPACITY];
   logic [IDB-1:0]                     cell_id [CAPACITY];
   ptns_pkg::tok_type                  tok_w [CAPACITY+1];

   logic signed [COORD_BITS-1:0]       best_x, best_y;
   logic [IDB-1:0]                     best_id;
   logic [D_W-1:0]                     best_d;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign action     = req_tuser;
   assign pos_x      = COORD_BITS'(req_tdata[15:0]);
   assign pos_y      = COORD_BITS'(req_tdata[31:16]);
   assign target_id  = req_tdata[38:32];
   assign count_inc  = {1'b0, count_ff} + 1'b1;
   assign new_id     = IDB'(count_inc);
   assign head_valid = (state_ff == S_QUERY) && (CNT_W'(step_ff) < count_ff);
   assign tok_w[0]   = '{tok: del_go_ff, found: 1'b0};

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      localparam int NXT = (i + 1) % CAPACITY;
      ptns_cell #(
         .COORD_BITS (COORD_BITS),
         .CNT_W      (CNT_W),
         .IDX        (i)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .ctl     (ctl),
         .count   (count_ff),
         .wr_x    (pos_x),
         .wr_y    (pos_y),
         .wr_id   (new_id),
         .nxt_x   (cell_x[NXT]),
         .nxt_y   (cell_y[NXT]),
         .nxt_id  (cell_id[NXT]),
         .tok_in  (tok_w[i]),
         .x       (cell_x[i]),
         .y       (cell_y[i]),
         .id      (cell_id[i]),
         .tok_out (tok_w[i+1])
      );
   end

   ptns_dist #(
      .COORD_BITS (COORD_BITS)
   ) u_dist (
      .clock    (clock),
      .reset    (reset),
      .start    (dist_start),
      .in_valid (head_valid),
      .head_x   (cell_x[0]),
      .head_y   (cell_y[0]),
      .head_id  (cell_id[0]),
      .qry_x    (qx_ff),
      .qry_y    (qy_ff),
      .best_x   (best_x),
      .best_y   (best_y),
      .best_id  (best_id),
      .best_d   (best_d)
   );

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      step_in       = step_ff;
      drain_in      = drain_ff;
      del_go_in     = 1'b0;
      tid_in        = tid_ff;
      qx_in         = qx_ff;
      qy_in         = qy_ff;
      res_status_in = res_status_ff;
      res_id_in     = res_id_ff;
      res_query_in  = res_query_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_tuser_in  = rsp_tuser_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      dist_start    = 1'b0;
      ctl.op        = ptns_pkg::CELL_HOLD;
      ctl.tid       = tid_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               res_query_in  = 1'b0;
               res_status_in = ptns_pkg::STAT_MISS;
               res_id_in     = '0;
               state_in      = S_DONE;
               unique case (action)
                  ptns_pkg::ACT_ADD: begin
                     if (count_ff == CNT_W'(CAPACITY)) begin
                        res_status_in = ptns_pkg::STAT_FULL;
                     end else begin
                        ctl.op        = ptns_pkg::CELL_WRITE;
                        count_in      = CNT_W'(count_inc);
                        res_status_in = ptns_pkg::STAT_OK;
                        res_id_in     = new_id;
                     end
                  end
                  ptns_pkg::ACT_DELETE: begin
                     tid_in    = target_id;
                     del_go_in = 1'b1;
                     state_in  = S_DELETE;
                  end
                  ptns_pkg::ACT_QUERY: begin
                     if (count_ff != '0) begin
                        qx_in      = pos_x;
                        qy_in      = pos_y;
                        step_in    = '0;
                        dist_start = 1'b1;
                        state_in   = S_QUERY;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_QUERY: begin
            ctl.op  = ptns_pkg::CELL_ROTATE;
            step_in = step_ff + 1'b1;
            if (step_ff == IDX_W'(CAPACITY - 1)) begin
               drain_in = 1'b0;
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            drain_in = 1'b1;
            if (drain_ff) begin
               res_query_in  = 1'b1;
               res_status_in = ptns_pkg::STAT_OK;
               state_in      = S_DONE;
            end
         end
         S_DELETE: begin
            if (tok_w[CAPACITY].tok) begin
               state_in = S_DONE;
               if (tok_w[CAPACITY].found) begin
                  ctl.op        = ptns_pkg::CELL_SHIFT;
                  count_in      = count_ff - 1'b1;
                  res_status_in = ptns_pkg::STAT_OK;
                  res_id_in     = tid_ff;
               end
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_tuser_in = res_status_ff;
               if (res_query_ff) begin
                  rsp_tdata_in = {ptns_pkg::DIST_BITS'(best_d), FB'(best_y),
                                  FB'(best_x), best_id};
               end else begin
                  rsp_tdata_in = {(ptns_pkg::RSP_TDATA_BITS - IDB)'(0), res_id_ff};
               end
               state_in = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      tid_ff        <= tid_in;
      qx_ff         <= qx_in;
      qy_ff         <= qy_in;
      step_ff       <= step_in;
      drain_ff      <= drain_in;
      res_status_ff <= res_status_in;
      res_id_ff     <= res_id_in;
      res_query_ff  <= res_query_in;
      rsp_tuser_ff  <= rsp_tuser_in;
      rsp_tdata_ff  <= rsp_tdata_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         del_go_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         del_go_ff    <= del_go_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

endmodule

FILE: sim/point_table_nearest_search_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_table_nearest_search_tb
// Self-checking bench for the point table with add, delete and nearest query.
// ----------------------------------------------------------------------------
// A short list of directed requests covers the empty table, coordinate
// extremes, tie breaking, duplicate ids, a full table and the unused action
// code. Random phases follow with changing mixes of adds, deletes and queries.
// Each response is compared with the fixed answer of its directed row, if any,
// or with a local model of the table. Both sides of the stream stall at random.
// ----------------------------------------------------------------------------

module point_table_nearest_search_tb;

   import ptns_pkg::*;

   localparam int CAPACITY = CAPACITY_DEF;
   localparam int PHASES = 17;
   localparam int PHASE_LEN = 50;
   localparam int PLAN_ROWS = 25;
   localparam logic [ACTION_BITS-1:0] ACT_UNUSED = 2'd3;

   typedef struct {
      logic [STATUS_BITS-1:0] status;
      logic [ID_BITS-1:0] id;
      logic signed [FIELD_BITS-1:0] x;
      logic signed [FIELD_BITS-1:0] y;
      logic [DIST_BITS-1:0] dsq;
   } answer_type;

   typedef struct packed {
      logic [ACTION_BITS-1:0] action;
      logic signed [FIELD_BITS-1:0] x;
      logic signed [FIELD_BITS-1:0] y;
      logic [ID_BITS-1:0] tid;
      int reps;
      bit typed;
      logic [STATUS_BITS-1:0] status;
      logic [ID_BITS-1:0] id;
      logic signed [FIELD_BITS-1:0] fx;
      logic signed [FIELD_BITS-1:0] fy;
      logic [DIST_BITS-1:0] dsq;
   } plan_row_type;

   // Rows that repeat use random coordinates.
   localparam plan_row_type PLAN [PLAN_ROWS] = '{
      '{ACT_QUERY,       0,      0,   0,  1, 1, STAT_MISS, 0,      0,      0, 0},
      '{ACT_DELETE,      0,      0,   1,  1, 1, STAT_MISS, 0,      0,      0, 0},
      '{ACT_UNUSED,  32767,     -1, 127,  1, 1, STAT_MISS, 0,      0,      0, 0},
      '{ACT_ADD,    -32768, -32768,   0,  1, 1, STAT_OK,   1,      0,      0, 0},
      '{ACT_ADD,     32767,  32767,   0,  1, 1, STAT_OK,   2,      0,      0, 0},
      '{ACT_QUERY,   32767, -32768,   0,  1, 1, STAT_OK,   1, -32768, -32768,
        33'd4294836225},
      '{ACT_QUERY,   32767,  32767,   0,  1, 1, STAT_OK,   2,  32767,  32767, 0},
      '{ACT_QUERY,       0,      0,   0,  1, 0, STAT_OK,   0,      0,      0, 0},
      '{ACT_UNUSED, -32768,  32767,   2,  1, 1, STAT_MISS, 0,      0,      0, 0},
      '{ACT_DELETE,      0,      0,   1,  1, 1, STAT_OK,   1,      0,      0, 0},
      '{ACT_DELETE,      0,      0,   1,  1, 1, STAT_MISS, 0,      0,      0, 0},
      '{ACT_ADD,         5,      5,   0,  1, 1, STAT_OK,   2,      0,      0, 0},
      '{ACT_QUERY,       5,      5,   0,  1, 1, STAT_OK,   2,      5,      5, 0},
      '{ACT_DELETE,      0,      0,   2,  1, 1, STAT_OK,   2,      0,      0, 0},
      '{ACT_QUERY,   32767,  32767,   0,  1, 0, STAT_OK,   0,      0,      0, 0},
      '{ACT_DELETE,      0,      0,   2,  1, 1, STAT_OK,   2,      0,      0, 0},
      '{ACT_QUERY,       0,      0,   0,  1, 1, STAT_MISS, 0,      0,      0, 0},
      '{ACT_ADD,         0,      0,   0, 64, 0, STAT_OK,   0,      0,      0, 0},
      '{ACT_ADD,         1,      1,   0,  1, 1, STAT_FULL, 0,      0,      0, 0},
      '{ACT_QUERY,       0,      0,   0,  1, 0, STAT_OK,   0,      0,      0, 0},
      '{ACT_DELETE,      0,      0,  64,  1, 1, STAT_OK,  64,      0,      0, 0},
      '{ACT_DELETE,      0,      0, 127,  1, 1, STAT_MISS, 0,      0,      0, 0},
      '{ACT_DELETE,      0,      0,   1,  1, 1, STAT_OK,   1,      0,      0, 0},
      '{ACT_ADD,        -1,      0,   0,  1, 1, STAT_OK,  63,      0,      0, 0},
      '{ACT_QUERY,      -1,      0,   0,  1, 0, STAT_OK,   0,      0,      0, 0}
   };

   logic clock;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [REQ_TDATA_BITS-1:0] req_tdata;
   logic [ACTION_BITS-1:0] req_tuser;
   logic rsp_tvalid;
   logic rsp_tready;
   logic [RSP_TDATA_BITS-1:0] rsp_tdata;
   logic [STATUS_BITS-1:0] rsp_tuser;

   logic signed [FIELD_BITS-1:0] pt_x [CAPACITY];
   logic signed [FIELD_BITS-1:0] pt_y [CAPACITY];
   logic [ID_BITS-1:0] pt_id [CAPACITY];
   int pt_count;

   answer_type expected_answers [$];
   int failures;
   int src_mode;
   int sink_mode;
   int sink_hold;

   point_table_nearest_search DUT (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic int pick_gap(input int mode);
      int r;
      r = $urandom_range(99);
      case (mode)
         0: begin
            return 0;
         end
         1: begin
            if (r < 70) return 0;
            if (r < 95) return $urandom_range(1, 3);
            return $urandom_range(10, 60);
         end
         default: begin
            if (r < 40) return 0;
            if (r < 85) return $urandom_range(1, 4);
            return $urandom_range(10, 60);
         end
      endcase
   endfunction

   function automatic logic signed [FIELD_BITS-1:0] pick_coord();
      int r;
      r = $urandom_range(99);
      if (r < 60) return FIELD_BITS'($urandom);
      if (r < 80) return FIELD_BITS'($signed($urandom_range(16)) - 8);
      case ($urandom_range(3))
         0: return 16'sh8000;
         1: return 16'sh7fff;
         2: return 16'sh0000;
         default: return 16'shffff;
      endcase
   endfunction

   function automatic answer_type apply_to_points(input logic [ACTION_BITS-1:0] action,
                                                  input logic signed [FIELD_BITS-1:0] px,
                                                  input logic signed [FIELD_BITS-1:0] py,
                                                  input logic [ID_BITS-1:0] tid);
      answer_type ans;
      int hit;
      int best;
      longint dx;
      longint dy;
      longint d;
      longint best_d;
      ans = '{STAT_MISS, '0, '0, '0, '0};
      best = 0;
      best_d = 0;
      case (action)
         ACT_ADD: begin
            if (pt_count >= CAPACITY) begin
               ans.status = STAT_FULL;
            end else begin
               pt_x[pt_count] = px;
               pt_y[pt_count] = py;
               pt_id[pt_count] = ID_BITS'(pt_count + 1);
               ans.status = STAT_OK;
               ans.id = pt_id[pt_count];
               pt_count++;
            end
         end
         ACT_DELETE: begin
            hit = -1;
            for (int i = 0; i < pt_count; i++) begin
               if (hit < 0 && pt_id[i] == tid) hit = i;
            end
            if (hit >= 0) begin
               for (int i = hit; i + 1 < pt_count; i++) begin
                  pt_x[i] = pt_x[i + 1];
                  pt_y[i] = pt_y[i + 1];
                  pt_id[i] = pt_id[i + 1];
               end
               pt_count--;
               ans.status = STAT_OK;
               ans.id = tid;
            end
         end
         ACT_QUERY: begin
            if (pt_count > 0) begin
               for (int i = 0; i < pt_count; i++) begin
                  dx = longint'(pt_x[i]) - longint'(px);
                  dy = longint'(pt_y[i]) - longint'(py);
                  d = dx * dx + dy * dy;
                  if (i == 0 || d < best_d) begin
                     best_d = d;
                     best = i;
                  end
               end
               ans.status = STAT_OK;
               ans.id = pt_id[best];
               ans.x = pt_x[best];
               ans.y = pt_y[best];
               ans.dsq = DIST_BITS'(best_d);
            end
         end
         default: begin
         end
      endcase
      return ans;
   endfunction

   task automatic send_request(input logic [ACTION_BITS-1:0] action,
                               input logic signed [FIELD_BITS-1:0] px,
                               input logic signed [FIELD_BITS-1:0] py,
                               input logic [ID_BITS-1:0] tid,
                               input bit typed,
                               input answer_type typed_ans);
      answer_type predicted;
      int gap;
      req_tvalid <= 1'b1;
      req_tdata <= {1'b0, tid, py, px};
      req_tuser <= action;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = apply_to_points(action, px, py, tid);
      expected_answers.push_back(typed ? typed_ans : predicted);
      gap = pick_gap(src_mode);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_answers.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (sink_hold > 0) begin
         rsp_tready <= 1'b0;
         sink_hold = sink_hold - 1;
      end else begin
         rsp_tready <= 1'b1;
         sink_hold = pick_gap(sink_mode);
      end
   end

   always @(posedge clock) begin
      answer_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_answers.size() == 0) begin
            $error("unexpected response: status %0d found_id %0d", rsp_tuser,
                   rsp_tdata[6:0]);
            failures++;
         end else begin
            want = expected_answers.pop_front();
            if (rsp_tuser !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_tuser);
               failures++;
            end
            if (rsp_tdata[6:0] !== want.id) begin
               $error("found_id: expected %0d, got %0d", want.id, rsp_tdata[6:0]);
               failures++;
            end
            if (rsp_tdata[22:7] !== want.x) begin
               $error("found_x: expected %0d, got %0d", want.x,
                      $signed(rsp_tdata[22:7]));
               failures++;
            end
            if (rsp_tdata[38:23] !== want.y) begin
               $error("found_y: expected %0d, got %0d", want.y,
                      $signed(rsp_tdata[38:23]));
               failures++;
            end
            if (rsp_tdata[71:39] !== want.dsq) begin
               $error("dist_sq: expected %0d, got %0d", want.dsq, rsp_tdata[71:39]);
               failures++;
            end
         end
      end
   end

   initial begin
      #10_000_000;
      $display("point_table_nearest_search_tb: errors");
      $finish;
   end

   initial begin
      plan_row_type row;
      answer_type typed_ans;
      logic [ACTION_BITS-1:0] action;
      logic [ID_BITS-1:0] tid;
      int add_pct;
      int r;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      rsp_tready = 1'b0;
      pt_count = 0;
      failures = 0;
      src_mode = 1;
      sink_mode = 1;
      sink_hold = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int n = 0; n < PLAN_ROWS; n++) begin
         row = PLAN[n];
         typed_ans = '{row.status, row.id, row.fx, row.fy, row.dsq};
         for (int k = 0; k < row.reps; k++) begin
            if (row.reps > 1) begin
               send_request(row.action, pick_coord(), pick_coord(), row.tid, row.typed,
                            typed_ans);
            end else begin
               send_request(row.action, row.x, row.y, row.tid, row.typed, typed_ans);
            end
         end
      end

      for (int phase = 0; phase < PHASES; phase++) begin
         case ($urandom_range(3))
            0: add_pct = 15;
            1: add_pct = 40;
            2: add_pct = 60;
            default: add_pct = 90;
         endcase
         src_mode = $urandom_range(2);
         sink_mode = $urandom_range(2);
         if (phase % 4 == 3) wait_for_drain();
         for (int k = 0; k < PHASE_LEN; k++) begin
            r = $urandom_range(99);
            if (r < add_pct) begin
               action = ACT_ADD;
            end else begin
               r = $urandom_range(99);
               if (r < 5) action = ACT_UNUSED;
               else if (r < 45) action = ACT_DELETE;
               else action = ACT_QUERY;
            end
            if (pt_count > 0 && $urandom_range(99) < 75) begin
               tid = pt_id[$urandom_range(pt_count - 1)];
            end else begin
               tid = ID_BITS'($urandom);
            end
            send_request(action, pick_coord(), pick_coord(), tid, 1'b0, typed_ans);
         end
      end

      wait_for_drain();
      repeat (2 * CAPACITY + 8) @(posedge clock);
      if (failures == 0 && expected_answers.size() == 0) begin
         $display("point_table_nearest_search_tb: clean");
      end else begin
         $display("point_table_nearest_search_tb: errors");
      end
      $finish;
   end

endmodule
